// File: src/rbf_pkg.sv
// Shared types and constants for the RGB 15x15 box filter.
package rbf_pkg;

  localparam int PIX_W        = 8;
  localparam int PIX_MAX      = (1 << PIX_W) - 1;
  localparam int CHANNELS     = 3;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = 3;
  localparam int OUT_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_t;

  // Per-pixel position flags carried down the pipeline
  typedef struct packed {
    logic row_zero;
    logic row_fill;
    logic col_zero;
    logic col_head;
    logic emit;
    logic last_col;
    logic last_row;
  } pos_t;

  typedef struct packed {
    rgb_t mean;
    logic row_end;
    logic frame_end;
  } res_t;

endpackage

// File: src/rbf_col_store.sv
// Line store and column-sum memory with read-modify-write of the running column sums.
module rbf_col_store import rbf_pkg::*; #(
  parameter int WINDOW_SIZE = 15,
  parameter int MAX_WIDTH   = 2048,
  parameter int COL_W       = $clog2(MAX_WIDTH),
  parameter int LA_W        = $clog2((WINDOW_SIZE - 1) * MAX_WIDTH),
  parameter int CS_W        = $clog2(WINDOW_SIZE * PIX_MAX + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           rd_en,
  input  logic [COL_W-1:0]               rd_col,
  input  logic [LA_W-1:0]                rd_addr,
  input  rgb_t                           rd_pix,
  input  pos_t                           rd_pos,
  output logic                           full_valid,
  output logic [CHANNELS-1:0][CS_W-1:0]  full_sum,
  output pos_t                           full_pos
);

  localparam int LS_DEPTH = (WINDOW_SIZE - 1) * MAX_WIDTH;

  typedef logic [CHANNELS-1:0][CS_W-1:0] csum_t;

  csum_t             cs_mem [MAX_WIDTH];
  rgb_t              ls_mem [LS_DEPTH];

  csum_t             cs_rd_r;
  rgb_t              ls_rd_r;
  logic              s1_v_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [LA_W-1:0]   s1_addr_r;
  rgb_t              s1_pix_r;
  pos_t              s1_pos_r;

  logic              s2_v_r;
  csum_t             s2_full_r;
  pos_t              s2_pos_r;

  csum_t                          full_nxt;
  csum_t                          csum_nxt;
  logic [CHANNELS-1:0][PIX_W-1:0] pix_a;
  logic [CHANNELS-1:0][PIX_W-1:0] ev_a;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cs_rd_r <= cs_mem[rd_col];
      ls_rd_r <= ls_mem[rd_addr];
    end
    if (s1_v_r) begin
      cs_mem[s1_col_r]  <= csum_nxt;
      ls_mem[s1_addr_r] <= s1_pix_r;
    end
  end

  // Row zero starts a fresh column; until the store holds WINDOW_SIZE-1
  // rows nothing is evicted.
  always_comb begin
    csum_t base;
    pix_a = s1_pix_r;
    ev_a  = ls_rd_r;
    base  = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      base[ch]     = s1_pos_r.row_zero ? '0 : cs_rd_r[ch];
      full_nxt[ch] = base[ch] + CS_W'(pix_a[ch]);
      csum_nxt[ch] = s1_pos_r.row_fill ? full_nxt[ch]
                   : cs_rd_r[ch] - CS_W'(ev_a[ch]) + CS_W'(pix_a[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_col_r  <= rd_col;
      s1_addr_r <= rd_addr;
      s1_pix_r  <= rd_pix;
      s1_pos_r  <= rd_pos;
    end
    if (s1_v_r) begin
      s2_full_r <= full_nxt;
      s2_pos_r  <= s1_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= rd_en;
      s2_v_r <= s1_v_r;
    end
  end

  assign full_valid = s2_v_r;
  assign full_sum   = s2_full_r;
  assign full_pos   = s2_pos_r;

endmodule

// File: src/rbf_out_fifo.sv
// Result queue between the filter pipeline and the output channel.
module rbf_out_fifo import rbf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic head_valid,
  output res_t head_data
);

  res_t                 mem_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r;
  logic [OUT_PTR_W-1:0] rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
      cnt_r <= cnt_r + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

endmodule

// File: src/rgb_box_filter_15x15.sv
// Top level of the streaming RGB box filter (per-channel 15x15 window mean).
// Pixels enter in raster order at up to one per clock; each window lying wholly
// inside the frame yields one result (sum of the window divided by the window
// area, truncated) once its bottom-right pixel passes the column-store stages,
// the window-sum and product registers, marked at row end and frame end. One
// pixel per clock while in_stall is low rests on the read-modify-write of the
// column-sum and line-store memories, each read and written once per pixel;
// results wait in an eight-entry queue, and in_stall rises only when that queue
// and the pipeline in front of it hold eight transactions. The line store keeps
// WINDOW_SIZE-1 rows of MAX_WIDTH pixels and needs no clearing after reset: the
// first row of each frame restarts the column sums. frame_width and frame_height
// are clamped to WINDOW_SIZE..MAX_WIDTH and WINDOW_SIZE..4095 and should change
// only between frames while the block is idle.
module rgb_box_filter_15x15 import rbf_pkg::*; #(
  parameter int WINDOW_SIZE = 15,
  parameter int MAX_WIDTH   = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIX_W-1:0]     in_pix_red,
  input  logic [PIX_W-1:0]     in_pix_green,
  input  logic [PIX_W-1:0]     in_pix_blue,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     out_mean_red,
  output logic [PIX_W-1:0]     out_mean_green,
  output logic [PIX_W-1:0]     out_mean_blue,
  output logic                 out_row_end,
  output logic                 out_frame_end
);

  localparam int STORED_ROWS = WINDOW_SIZE - 1;
  localparam int AREA        = WINDOW_SIZE * WINDOW_SIZE;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int LA_W        = $clog2(STORED_ROWS * MAX_WIDTH);
  localparam int CS_W        = $clog2(WINDOW_SIZE * PIX_MAX + 1);
  localparam int WS_W        = $clog2(AREA * PIX_MAX + 1);
  localparam int MW_W        = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W       = (MW_W > CFG_W) ? MW_W : CFG_W;
  localparam int RW1_W       = CFG_W + 1;
  localparam int BASE_LAST   = (STORED_ROWS - 1) * MAX_WIDTH;
  // Division by the area as multiply by a rounded-up reciprocal and shift;
  // exact while area * max_sum < 2^DIV_K.
  localparam int DIV_K       = $clog2(AREA * AREA * PIX_MAX) + 1;
  localparam longint DIV_M_L = ((longint'(1) << DIV_K) + AREA - 1) / AREA;
  localparam int M_W         = $clog2(DIV_M_L + 1);
  localparam int PROD_W      = WS_W + M_W;
  localparam logic [M_W-1:0] DIV_M = M_W'(DIV_M_L);

  typedef logic [CHANNELS-1:0][CS_W-1:0]   csum_t;
  typedef logic [CHANNELS-1:0][WS_W-1:0]   wsum_t;
  typedef logic [CHANNELS-1:0][PROD_W-1:0] prod_t;

  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [CFG_W-1:0] row_r;
  logic [CFG_W-1:0] row_nxt;
  logic [LA_W-1:0]  base_r;
  logic [LA_W-1:0]  base_nxt;
  logic [OUT_CNT_W-1:0] occ_r;
  logic [OUT_CNT_W-1:0] occ_nxt;

  logic [CMP_W-1:0] fw;
  logic [CMP_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;
  logic             last_col;
  logic             last_row;
  logic             in_acc;
  logic             pop;
  logic             retire;
  pos_t             pos;
  rgb_t             pix;
  logic [LA_W-1:0]  addr;

  logic             v2;
  csum_t            full;
  pos_t             pos2;

  csum_t            sh_r [WINDOW_SIZE];
  wsum_t            win_r;
  wsum_t            win_nxt;
  logic             s3_v_r;
  logic             s3_row_end_r;
  logic             s3_frame_end_r;
  prod_t            prod_r;
  logic             s4_v_r;
  logic             s4_row_end_r;
  logic             s4_frame_end_r;

  res_t             push_data;
  res_t             head;

  assign in_stall = (occ_r >= OUT_CNT_W'(OUT_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign pix      = '{red: in_pix_red, green: in_pix_green, blue: in_pix_blue};

  always_comb begin
    fw = CMP_W'(frame_width_r);
    if (fw < CMP_W'(WINDOW_SIZE)) begin
      eff_w = CMP_W'(WINDOW_SIZE);
    end else if (fw > CMP_W'(MAX_WIDTH)) begin
      eff_w = CMP_W'(MAX_WIDTH);
    end else begin
      eff_w = fw;
    end
    // upper height bound is the register's full scale
    eff_h = (frame_height_r < CFG_W'(WINDOW_SIZE)) ? CFG_W'(WINDOW_SIZE) : frame_height_r;

    last_col = (CMP_W'(col_r) + CMP_W'(1)) >= eff_w;
    last_row = (RW1_W'(row_r) + RW1_W'(1)) >= RW1_W'(eff_h);

    pos.row_zero = (row_r == '0);
    pos.row_fill = (row_r < CFG_W'(STORED_ROWS));
    pos.col_zero = (col_r == '0);
    pos.col_head = (col_r < COL_W'(WINDOW_SIZE));
    pos.emit     = !pos.row_fill && (col_r >= COL_W'(WINDOW_SIZE - 1));
    pos.last_col = last_col;
    pos.last_row = last_row;

    addr = base_r + LA_W'(col_r);

    col_nxt  = last_col ? '0 : col_r + COL_W'(1);
    row_nxt  = row_r;
    base_nxt = base_r;
    if (last_col) begin
      row_nxt = last_row ? '0 : row_r + CFG_W'(1);
      if (last_row || base_r == LA_W'(BASE_LAST)) begin
        base_nxt = '0;
      end else begin
        base_nxt = base_r + LA_W'(MAX_WIDTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= CFG_W'(WIDTH_RESET);
      frame_height_r <= CFG_W'(HEIGHT_RESET);
      col_r          <= '0;
      row_r          <= '0;
      base_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        endcase
      end
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        base_r <= base_nxt;
      end
    end
  end

  rbf_col_store #(
    .WINDOW_SIZE (WINDOW_SIZE),
    .MAX_WIDTH   (MAX_WIDTH)
  ) u_col_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_acc),
    .rd_col     (col_r),
    .rd_addr    (addr),
    .rd_pix     (pix),
    .rd_pos     (pos),
    .full_valid (v2),
    .full_sum   (full),
    .full_pos   (pos2)
  );

  // Running window sum over the last WINDOW_SIZE full column sums of the row
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (pos2.col_zero) begin
        win_nxt[ch] = WS_W'(full[ch]);
      end else if (pos2.col_head) begin
        win_nxt[ch] = win_r[ch] + WS_W'(full[ch]);
      end else begin
        win_nxt[ch] = win_r[ch] + WS_W'(full[ch]) - WS_W'(sh_r[WINDOW_SIZE-1][ch]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      sh_r[0] <= full;
      for (int i = 1; i < WINDOW_SIZE; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
      win_r          <= win_nxt;
      s3_row_end_r   <= pos2.last_col;
      s3_frame_end_r <= pos2.last_col && pos2.last_row;
    end
    if (s3_v_r) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        prod_r[ch] <= PROD_W'(win_r[ch]) * PROD_W'(DIV_M);
      end
      s4_row_end_r   <= s3_row_end_r;
      s4_frame_end_r <= s3_frame_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      occ_r  <= '0;
    end else begin
      s3_v_r <= v2 && pos2.emit;
      s4_v_r <= s3_v_r;
      occ_r  <= occ_nxt;
    end
  end

  // Occupancy counts transactions accepted and not yet delivered or dropped
  assign retire  = v2 && !pos2.emit;
  assign pop     = out_valid && !out_stall;
  assign occ_nxt = occ_r + OUT_CNT_W'(in_acc) - OUT_CNT_W'(retire) - OUT_CNT_W'(pop);

  assign push_data.mean.red   = prod_r[2][DIV_K +: PIX_W];
  assign push_data.mean.green = prod_r[1][DIV_K +: PIX_W];
  assign push_data.mean.blue  = prod_r[0][DIV_K +: PIX_W];
  assign push_data.row_end    = s4_row_end_r;
  assign push_data.frame_end  = s4_frame_end_r;

  rbf_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s4_v_r),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (out_valid),
    .head_data  (head)
  );

  assign out_mean_red   = head.mean.red;
  assign out_mean_green = head.mean.green;
  assign out_mean_blue  = head.mean.blue;
  assign out_row_end    = head.row_end;
  assign out_frame_end  = head.frame_end;

endmodule

// File: src/rbf_checker.sv
// Port-level assertions for the RGB box filter, bound to the top level.
module rbf_checker import rbf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [PIX_W-1:0]     in_pix_red,
  input logic [PIX_W-1:0]     in_pix_green,
  input logic [PIX_W-1:0]     in_pix_blue,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [PIX_W-1:0]     out_mean_red,
  input logic [PIX_W-1:0]     out_mean_green,
  input logic [PIX_W-1:0]     out_mean_blue,
  input logic                 out_row_end,
  input logic                 out_frame_end
);

  // The last result of a frame is also the last of its row
  a_frame_end_row_end: assert property (@(posedge clk)
    out_valid && out_frame_end |-> out_row_end)
    else $error("frame end without row end");

  // Reset empties the result queue and frees the input
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall present after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result transaction withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_mean_red) && $stable(out_mean_green)
      && $stable(out_mean_blue) && $stable(out_row_end) && $stable(out_frame_end))
    else $error("result payload changed while stalled");

endmodule

bind rgb_box_filter_15x15 rbf_checker u_rbf_checker (.*);
